/* src/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the periodic task timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam int ID_W         = 16;
    localparam int PERIOD_W     = 16;
    localparam int TASK_COUNT_W = 5;
    localparam int MODE_W       = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FAIL     = 2'd1,
        ST_DISPATCH = 2'd2,
        ST_NONE_DUE = 2'd3
    } status_t;

    typedef struct packed {
        status_t                 status;
        logic [ID_W-1:0]         task_id;
        logic [TASK_COUNT_W-1:0] task_count;
        logic                    last;
    } result_t;

endpackage

/* src/ptt_result_reg.sv */
// ----------------------------------------------------------------------------
// ptt_result_reg
// Output register for result items; frees the table walk from the sink.
// ----------------------------------------------------------------------------
module ptt_result_reg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  ptt_pkg::result_t                res,
    output logic                            space,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], task_id_res[17:2], task_count[22:18], zero[23]
    output logic [ptt_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    logic             valid_reg;
    ptt_pkg::result_t data_reg;

    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tlast  = data_reg.last;
    assign m_tdata  = {1'b0, data_reg.task_count, data_reg.task_id, data_reg.status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= res;
        end
    end

endmodule

/* src/periodic_task_timer_table.sv */
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// Table of periodic tasks kept in one synchronous entry memory.
// ----------------------------------------------------------------------------
// Each entry (handle, period, countdown, run flag) lives in a single memory
// with one read and one write port and a registered read. Tick, scan and the
// handle lookup of delete, set run flag and set period walk the live entries
// one per cycle, reading entry i while writing back entry i-1; a lookup
// stops at the first match, delete then copies the last entry into the
// matched slot, and create or an unknown mode goes straight to its final item.
// The walk pauses while a scan has a dispatch item to hand over and the
// output register is full, and the final item of every operation waits the
// same way for a free slot. Entries need no clearing after reset: only
// entries below the count are read.
// ----------------------------------------------------------------------------
module periodic_task_timer_table
#(
    parameter int MAX_TASKS = ptt_pkg::MAX_TASKS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // task_id[15:0], period[31:16], run_enable[32], zero[39:33]
    input  logic [ptt_pkg::IN_TDATA_W-1:0]  s_tdata,
    // mode[2:0]
    input  logic [ptt_pkg::MODE_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], task_id_res[17:2], task_count[22:18], zero[23]
    output logic [ptt_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam logic [ptt_pkg::MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [ptt_pkg::MODE_W-1:0] MODE_SCAN    = 3'd1;
    localparam logic [ptt_pkg::MODE_W-1:0] MODE_CREATE  = 3'd2;
    localparam logic [ptt_pkg::MODE_W-1:0] MODE_DELETE  = 3'd3;
    localparam logic [ptt_pkg::MODE_W-1:0] MODE_SET_RUN = 3'd4;
    localparam logic [ptt_pkg::MODE_W-1:0] MODE_SET_PER = 3'd5;

    typedef struct packed {
        logic [ptt_pkg::ID_W-1:0]     handle;
        logic [ptt_pkg::PERIOD_W-1:0] period;
        logic [ptt_pkg::PERIOD_W-1:0] countdown;
        logic                         enable;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DEL_WRITE,
        S_FINISH
    } state_t;

    // input fields
    logic [ptt_pkg::ID_W-1:0]     in_id;
    logic [ptt_pkg::PERIOD_W-1:0] in_period;
    logic                         in_enable;

    assign in_id     = s_tdata[15:0];
    assign in_period = s_tdata[31:16];
    assign in_enable = s_tdata[32];

    // entry memory
    entry_t     mem [0:MAX_TASKS-1];
    entry_t     rd_data_reg;
    logic       rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic       we;
    logic [IDX_W-1:0] wa;
    entry_t     wd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    state_t                       state_reg, state_next;
    logic [ptt_pkg::MODE_W-1:0]   op_reg, op_next;
    logic [ptt_pkg::ID_W-1:0]     id_reg, id_next;
    logic [ptt_pkg::PERIOD_W-1:0] per_reg, per_next;
    logic                         en_reg, en_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             issue_reg, issue_next;
    logic [IDX_W-1:0]             proc_reg, proc_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic                         pend_vld_reg, pend_vld_next;
    logic [ptt_pkg::ID_W-1:0]     pend_id_reg, pend_id_next;
    ptt_pkg::status_t             fin_status_reg, fin_status_next;
    logic [ptt_pkg::ID_W-1:0]     fin_id_reg, fin_id_next;

    // output register
    logic             out_space;
    logic             push;
    ptt_pkg::result_t push_res;

    ptt_result_reg u_result_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res      (push_res),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign s_tready = (state_reg == S_IDLE);

    logic [CNT_W-1:0] cnt_last;
    logic             due;
    logic             match;
    logic             is_lookup;
    logic             stall;
    logic             found;

    assign cnt_last  = count_reg - 1'b1;
    assign due       = (rd_data_reg.countdown == '0) && rd_data_reg.enable;
    assign match     = (rd_data_reg.handle == id_reg);
    assign is_lookup = (op_reg == MODE_DELETE) || (op_reg == MODE_SET_RUN)
                       || (op_reg == MODE_SET_PER);
    assign stall     = (op_reg == MODE_SCAN) && rd_vld_reg && due && pend_vld_reg
                       && !out_space;
    assign found     = rd_vld_reg && match && is_lookup;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        per_next        = per_reg;
        en_next         = en_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        proc_next       = proc_reg;
        rd_vld_next     = rd_vld_reg;
        pend_vld_next   = pend_vld_reg;
        pend_id_next    = pend_id_reg;
        fin_status_next = fin_status_reg;
        fin_id_next     = fin_id_reg;

        rd_en   = 1'b0;
        rd_addr = issue_reg[IDX_W-1:0];
        we      = 1'b0;
        wa      = proc_reg;
        wd      = rd_data_reg;

        push     = 1'b0;
        push_res = '{status:     ptt_pkg::ST_DISPATCH,
                     task_id:    pend_id_reg,
                     task_count: ptt_pkg::TASK_COUNT_W'(count_reg),
                     last:       1'b0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next       = s_tuser;
                    id_next       = in_id;
                    per_next      = in_period;
                    en_next       = in_enable;
                    issue_next    = '0;
                    rd_vld_next   = 1'b0;
                    pend_vld_next = 1'b0;
                    fin_id_next   = '0;
                    unique case (s_tuser)
                        MODE_TICK, MODE_SCAN, MODE_DELETE, MODE_SET_RUN, MODE_SET_PER:
                        begin
                            state_next = S_WALK;
                        end
                        MODE_CREATE:
                        begin
                            state_next = S_FINISH;
                            if (count_reg < CNT_W'(MAX_TASKS))
                            begin
                                we           = 1'b1;
                                wa           = count_reg[IDX_W-1:0];
                                wd.handle    = in_id;
                                wd.period    = in_period;
                                wd.countdown = in_period;
                                wd.enable    = 1'b1;
                                count_next   = count_reg + 1'b1;
                                fin_status_next = ptt_pkg::ST_OK;
                            end
                            else
                            begin
                                fin_status_next = ptt_pkg::ST_FAIL;
                            end
                        end
                        default:
                        begin
                            state_next      = S_FINISH;
                            fin_status_next = ptt_pkg::ST_FAIL;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (!stall)
                begin
                    // write back the entry held in the read register
                    if (rd_vld_reg)
                    begin
                        case (op_reg)
                            MODE_TICK:
                            begin
                                if (rd_data_reg.countdown != '0)
                                begin
                                    we           = 1'b1;
                                    wd.countdown = rd_data_reg.countdown - 1'b1;
                                end
                            end
                            MODE_SCAN:
                            begin
                                if (due)
                                begin
                                    we            = 1'b1;
                                    wd.countdown  = rd_data_reg.period;
                                    // hand over the previous dispatch, hold this one
                                    push          = pend_vld_reg;
                                    pend_vld_next = 1'b1;
                                    pend_id_next  = rd_data_reg.handle;
                                end
                            end
                            MODE_SET_RUN:
                            begin
                                if (match)
                                begin
                                    we        = 1'b1;
                                    wd.enable = en_reg;
                                end
                            end
                            MODE_SET_PER:
                            begin
                                if (match)
                                begin
                                    we           = 1'b1;
                                    wd.period    = per_reg;
                                    wd.countdown = per_reg;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end

                    if (found)
                    begin
                        rd_vld_next = 1'b0;
                        if (op_reg == MODE_DELETE)
                        begin
                            // fetch the last entry to move into the matched slot
                            rd_en      = 1'b1;
                            rd_addr    = cnt_last[IDX_W-1:0];
                            state_next = S_DEL_WRITE;
                        end
                        else
                        begin
                            fin_status_next = ptt_pkg::ST_OK;
                            state_next      = S_FINISH;
                        end
                    end
                    else if (issue_reg < count_reg)
                    begin
                        rd_en       = 1'b1;
                        issue_next  = issue_reg + 1'b1;
                        proc_next   = issue_reg[IDX_W-1:0];
                        rd_vld_next = 1'b1;
                    end
                    else
                    begin
                        rd_vld_next = 1'b0;
                        state_next  = S_FINISH;
                        case (op_reg)
                            MODE_TICK:
                            begin
                                fin_status_next = ptt_pkg::ST_OK;
                            end
                            MODE_SCAN:
                            begin
                                fin_status_next = pend_vld_next ? ptt_pkg::ST_DISPATCH
                                                                : ptt_pkg::ST_NONE_DUE;
                                fin_id_next     = pend_vld_next ? pend_id_next : '0;
                            end
                            MODE_DELETE:
                            begin
                                fin_status_next = (count_reg != '0) ? ptt_pkg::ST_OK
                                                                    : ptt_pkg::ST_FAIL;
                            end
                            default:
                            begin
                                fin_status_next = ptt_pkg::ST_FAIL;
                            end
                        endcase
                    end
                end
            end

            S_DEL_WRITE:
            begin
                we              = 1'b1;
                wa              = proc_reg;
                wd              = rd_data_reg;
                count_next      = cnt_last;
                fin_status_next = ptt_pkg::ST_OK;
                state_next      = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_space)
                begin
                    push       = 1'b1;
                    push_res   = '{status:     fin_status_reg,
                                   task_id:    fin_id_reg,
                                   task_count: ptt_pkg::TASK_COUNT_W'(count_reg),
                                   last:       1'b1};
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        per_reg        <= per_next;
        en_reg         <= en_next;
        proc_reg       <= proc_next;
        pend_id_reg    <= pend_id_next;
        fin_status_reg <= fin_status_next;
        fin_id_reg     <= fin_id_next;
    end

endmodule

/* bench/periodic_task_timer_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_timer_table_tb
// Self-checking bench for the periodic task timer table.
// ----------------------------------------------------------------------------
// Drives tick, scan, create, delete, set run flag and set period items into
// the stream input, mirrors the task table in a scoreboard and checks every
// result item field by field in order. A directed opening covers the empty
// and full table, zero and maximum periods, duplicate handles and the unused
// modes; a long random part follows with random idling on both sides, one
// long receiver hold-off and one pause until the table has drained.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_tb;

    localparam int TABLE_DEPTH   = ptt_pkg::MAX_TASKS_DEF;
    localparam int RANDOM_ITEMS  = 425;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT_ITEM  = 120;
    localparam int PAUSE_AT_ITEM = 300;
    localparam int DRAIN_CYCLES  = TABLE_DEPTH + 40;

    typedef enum logic [ptt_pkg::MODE_W-1:0] {
        OP_TICK       = 3'd0,
        OP_SCAN       = 3'd1,
        OP_CREATE     = 3'd2,
        OP_DELETE     = 3'd3,
        OP_SET_RUN    = 3'd4,
        OP_SET_PERIOD = 3'd5,
        OP_UNUSED6    = 3'd6,
        OP_UNUSED7    = 3'd7
    } op_t;

    // Mirror of the task table plus the queue of result items still owed.
    class task_table_scoreboard;
        logic [ptt_pkg::ID_W-1:0]     handle_tab    [TABLE_DEPTH];
        logic [ptt_pkg::PERIOD_W-1:0] period_tab    [TABLE_DEPTH];
        logic [ptt_pkg::PERIOD_W-1:0] countdown_tab [TABLE_DEPTH];
        logic                         enable_tab    [TABLE_DEPTH];
        int                           entries;
        ptt_pkg::result_t             expected_results[$];
        int                           errors;
        int                           results_seen;
        int                           dispatches;
        int                           full_rejects;
        int                           items_noted;

        function new();
            entries      = 0;
            errors       = 0;
            results_seen = 0;
            dispatches   = 0;
            full_rejects = 0;
            items_noted  = 0;
        endfunction

        function int find_entry(logic [ptt_pkg::ID_W-1:0] id);
            for (int i = 0; i < entries; i++)
                if (handle_tab[i] == id)
                    return i;
            return -1;
        endfunction

        // Handle of a live entry, or any handle when the table is empty.
        function logic [ptt_pkg::ID_W-1:0] pick_handle();
            if (entries == 0)
                return ptt_pkg::ID_W'($urandom_range(0, 65535));
            return handle_tab[$urandom_range(0, entries - 1)];
        endfunction

        function void push_result(ptt_pkg::status_t st, logic [ptt_pkg::ID_W-1:0] id,
                                  logic fin);
            ptt_pkg::result_t r;
            r.status     = st;
            r.task_id    = id;
            r.task_count = ptt_pkg::TASK_COUNT_W'(entries);
            r.last       = fin;
            expected_results.push_back(r);
        endfunction

        function void note_item(op_t op, logic [ptt_pkg::ID_W-1:0] id,
                                logic [ptt_pkg::PERIOD_W-1:0] per, logic en);
            ptt_pkg::status_t st;
            int               idx;
            int               last_due;
            st  = ptt_pkg::ST_FAIL;
            idx = find_entry(id);
            items_noted++;
            case (op)
                OP_TICK:
                begin
                    for (int i = 0; i < entries; i++)
                        if (countdown_tab[i] != '0)
                            countdown_tab[i] = countdown_tab[i] - 1'b1;
                    st = ptt_pkg::ST_OK;
                end
                OP_SCAN:
                begin
                    last_due = -1;
                    for (int i = 0; i < entries; i++)
                        if (countdown_tab[i] == '0 && enable_tab[i])
                            last_due = i;
                    if (last_due < 0)
                    begin
                        push_result(ptt_pkg::ST_NONE_DUE, '0, 1'b1);
                        return;
                    end
                    for (int i = 0; i <= last_due; i++)
                        if (countdown_tab[i] == '0 && enable_tab[i])
                        begin
                            countdown_tab[i] = period_tab[i];
                            push_result(ptt_pkg::ST_DISPATCH, handle_tab[i], i == last_due);
                        end
                    return;
                end
                OP_CREATE:
                begin
                    if (entries < TABLE_DEPTH)
                    begin
                        handle_tab[entries]    = id;
                        period_tab[entries]    = per;
                        countdown_tab[entries] = per;
                        enable_tab[entries]    = 1'b1;
                        entries++;
                        st = ptt_pkg::ST_OK;
                    end
                    else
                        full_rejects++;
                end
                OP_DELETE:
                begin
                    if (entries > 0)
                    begin
                        // move the last entry into the freed slot
                        if (idx >= 0)
                        begin
                            handle_tab[idx]    = handle_tab[entries - 1];
                            period_tab[idx]    = period_tab[entries - 1];
                            countdown_tab[idx] = countdown_tab[entries - 1];
                            enable_tab[idx]    = enable_tab[entries - 1];
                            entries--;
                        end
                        st = ptt_pkg::ST_OK;
                    end
                end
                OP_SET_RUN:
                begin
                    if (idx >= 0)
                    begin
                        enable_tab[idx] = en;
                        st = ptt_pkg::ST_OK;
                    end
                end
                OP_SET_PERIOD:
                begin
                    if (idx >= 0)
                    begin
                        period_tab[idx]    = per;
                        countdown_tab[idx] = per;
                        st = ptt_pkg::ST_OK;
                    end
                end
                default:
                    st = ptt_pkg::ST_FAIL;
            endcase
            push_result(st, '0, 1'b1);
        endfunction

        function void check_result(logic [ptt_pkg::OUT_TDATA_W-1:0] data, logic lst);
            ptt_pkg::result_t                 want;
            logic [1:0]                       got_status;
            logic [ptt_pkg::ID_W-1:0]         got_id;
            logic [ptt_pkg::TASK_COUNT_W-1:0] got_count;
            got_status = data[1:0];
            got_id     = data[17:2];
            got_count  = data[22:18];
            results_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result item status=%0d id=%h count=%0d last=%b",
                             got_status, got_id, got_count, lst);
                return;
            end
            want = expected_results.pop_front();
            if (want.status == ptt_pkg::ST_DISPATCH)
                dispatches++;
            if (got_status !== want.status || got_id !== want.task_id ||
                got_count !== want.task_count || lst !== want.last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $write("ERROR: result %0d expected status=%0d id=%h count=%0d last=%b",
                           results_seen, want.status, want.task_id, want.task_count,
                           want.last);
                    $display(" got status=%0d id=%h count=%0d last=%b",
                             got_status, got_id, got_count, lst);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ptt_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic [ptt_pkg::MODE_W-1:0]      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ptt_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;

    task_table_scoreboard sb;
    bit                   hold_request;
    int                   items_sent;

    periodic_task_timer_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Wait the drawn gap, offer one item and hold it until accepted.
    task automatic send_item(op_t op, logic [ptt_pkg::ID_W-1:0] id,
                             logic [ptt_pkg::PERIOD_W-1:0] per, logic en, bit no_gap);
        int   gap;
        logic rdy;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, en, per, id};
        s_tuser  <= op;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        sb.note_item(op, id, per, en);
        items_sent++;
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    task automatic random_item(bit no_gap);
        int                           pick;
        op_t                          op;
        logic [ptt_pkg::ID_W-1:0]     id;
        logic [ptt_pkg::PERIOD_W-1:0] per;
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_TICK;
        else if (pick < 55) op = OP_SCAN;
        else if (pick < 71) op = OP_CREATE;
        else if (pick < 81) op = OP_DELETE;
        else if (pick < 89) op = OP_SET_RUN;
        else if (pick < 96) op = OP_SET_PERIOD;
        else                op = ($urandom_range(0, 1) == 0) ? OP_UNUSED6 : OP_UNUSED7;
        // short periods keep tasks coming due; a few span the full range
        if ($urandom_range(0, 9) < 7)
            per = ptt_pkg::PERIOD_W'($urandom_range(0, 6));
        else
            per = ptt_pkg::PERIOD_W'($urandom_range(0, 65535));
        if (op == OP_CREATE)
            id = ($urandom_range(0, 1) == 0) ? ptt_pkg::ID_W'($urandom_range(0, 31))
                                              : ptt_pkg::ID_W'($urandom_range(0, 65535));
        else if ($urandom_range(0, 9) < 8)
            id = sb.pick_handle();
        else
            id = ptt_pkg::ID_W'($urandom_range(0, 65535));
        send_item(op, id, per, 1'($urandom_range(0, 1)), no_gap);
    endtask

    // Result side: random stalls, one long hold-off on request.
    initial
    begin
        int                              stall;
        logic                            v;
        logic                            l;
        logic [ptt_pkg::OUT_TDATA_W-1:0] d;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            stall = ((sb.results_seen / 64) % 4 == 2) ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                v = m_tvalid;
                d = m_tdata;
                l = m_tlast;
                @(posedge clk);
            end
            while (!v);
            sb.check_result(d, l);
        end
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [ptt_pkg::ID_W-1:0]     id;
        logic [ptt_pkg::PERIOD_W-1:0] per;
        sb           = new();
        hold_request = 1'b0;
        items_sent   = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: every lookup fails, scan finds nothing due
        send_item(OP_TICK, 16'h0000, 16'h0000, 1'b0, 0);
        send_item(OP_SCAN, 16'hFFFF, 16'hFFFF, 1'b1, 0);
        send_item(OP_DELETE, 16'h0000, 16'h0000, 1'b0, 0);
        send_item(OP_SET_RUN, 16'h0005, 16'h0000, 1'b1, 0);
        send_item(OP_SET_PERIOD, 16'h0005, 16'h0003, 1'b0, 0);
        send_item(OP_UNUSED6, 16'hFFFF, 16'hFFFF, 1'b1, 0);
        send_item(OP_UNUSED7, 16'h0000, 16'h0000, 1'b0, 0);

        // fill the table: zero and max periods, extreme and duplicate handles
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == 0)      id = 16'h0000;
            else if (i < 3)  id = 16'hFFFF;
            else             id = ptt_pkg::ID_W'($urandom_range(0, 65535));
            if (i == 1)          per = 16'hFFFF;
            else if (i % 3 == 0) per = 16'h0000;
            else                 per = ptt_pkg::PERIOD_W'($urandom_range(1, 4));
            send_item(OP_CREATE, id, per, 1'b0, 0);
        end
        send_item(OP_SCAN, 16'h0000, 16'h0000, 1'b0, 0);
        send_item(OP_CREATE, 16'h1234, 16'h0001, 1'b0, 0);
        send_item(OP_DELETE, 16'hFFFF, 16'h0000, 1'b0, 0);
        send_item(OP_SET_RUN, 16'h0000, 16'h0000, 1'b0, 0);
        send_item(OP_SET_PERIOD, 16'hFFFF, 16'h0000, 1'b1, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == HOLD_AT_ITEM)
                hold_request = 1'b1;
            if (n == PAUSE_AT_ITEM)
                wait_drained();
            random_item(n >= 200 && n < 260);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items through the table, checked %0d result items, %0d dispatches.",
                 items_sent, sb.results_seen, sb.dispatches);
        $display("Full-table create rejects: %0d; long output hold-off and full drain pause done.",
                 sb.full_rejects);
        if (sb.pending() > 0)
            $display("ERROR: %0d expected result items never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
